@@ design/ssvm_pkg.sv @@
// Shared types, constants and the cosine table generator of the soft spherical mask.
package ssvm_pkg;

	// Default sizes handed to the top level parameters
	localparam int unsigned MAX_GRID_DEF  = 256;
	localparam int unsigned COS_DEPTH_DEF = 256;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_EDGE   = 2'd0,
		REG_MASK_RADIUS = 2'd1,
		REG_EDGE_WIDTH  = 2'd2
	} ssvm_reg_t;

	localparam logic [8:0]  GRID_EDGE_RST   = 9'd128;
	localparam logic [15:0] MASK_RADIUS_RST = 16'd12288;
	localparam logic [15:0] EDGE_WIDTH_RST  = 16'd1280;

	// Unity weight in Q1.15
	localparam logic [15:0] WEIGHT_ONE = 16'h8000;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// Sideband that travels with each voxel through the root and divide pipeline
	typedef struct packed {
		logic signed [15:0] voxel;
		logic               last;
		logic               pass;
		logic               inband;
	} ssvm_side_t;

	// Divide one Taylor term by (2k-1)*2k
	function automatic longint unsigned taylor_div(input longint unsigned t, input int k);
		case (k)
			1:       taylor_div = t / 2;
			2:       taylor_div = t / 12;
			3:       taylor_div = t / 30;
			4:       taylor_div = t / 56;
			5:       taylor_div = t / 90;
			6:       taylor_div = t / 132;
			7:       taylor_div = t / 182;
			8:       taylor_div = t / 240;
			default: taylor_div = t;
		endcase
	endfunction

	// Quarter-wave cosine entry in unsigned Q1.15, evaluated at elaboration
	function automatic logic [15:0] cos_entry(input int unsigned idx, input int unsigned Depth);
		longint unsigned u;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		longint          w;
		u    = (longint'(idx) << 30) / Depth;
		x    = (u * HALF_PI_Q30) >> 30;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = 64'sd1 << 30;
		for (int k = 1; k <= 8; k++) begin
			term = taylor_div((term * x2) >> 30, k);
			if ((k & 1) != 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		w = (sum > 0) ? ((sum + 64'sd16384) >>> 15) : 64'sd0;
		if (w > 64'sd32768) begin
			w = 64'sd32768;
		end
		return 16'(w);
	endfunction

endpackage

@@ design/ssvm_root_div.sv @@
// Pipelined square root of the scaled distance and band phase divider, one bit per stage.
module ssvm_root_div #(
	parameter int unsigned MAX_GRID        = ssvm_pkg::MAX_GRID_DEF,
	parameter int unsigned COS_TABLE_DEPTH = ssvm_pkg::COS_DEPTH_DEF,
	parameter int unsigned DSW             = 2 * $clog2(MAX_GRID) + 18,
	parameter int unsigned QB              = $clog2(COS_TABLE_DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [DSW-1:0]       in_d2s,
	input  ssvm_pkg::ssvm_side_t in_side,
	input  logic [15:0]          mask_radius,
	input  logic [15:0]          edge_width,
	output logic                 out_valid,
	output logic [QB-1:0]        out_idx,
	output logic                 out_zero,
	output ssvm_pkg::ssvm_side_t out_side
);
	import ssvm_pkg::*;

	localparam int unsigned RW   = DSW / 2;
	localparam int unsigned NUMW = 16 + $clog2(COS_TABLE_DEPTH + 1);

	typedef struct packed {
		logic [DSW-1:0] rem;
		logic [DSW-1:0] root;
	} sq_t;

	typedef struct packed {
		logic [NUMW-1:0] num;
		logic [QB-1:0]   quo;
	} dv_t;

	// One non-restoring-free digit of the integer square root
	function automatic sq_t sq_step(input sq_t a, input int unsigned k);
		logic [DSW-1:0] bit_v;
		logic [DSW-1:0] trial;
		sq_t            r;
		bit_v = DSW'(1) << (2 * (RW - 1 - k));
		trial = a.root + bit_v;
		if (a.rem >= trial) begin
			r.rem  = a.rem - trial;
			r.root = (a.root >> 1) + bit_v;
		end else begin
			r.rem  = a.rem;
			r.root = a.root >> 1;
		end
		return r;
	endfunction

	// One quotient bit of the restoring divide
	function automatic dv_t dv_step(input dv_t a, input int unsigned j, input logic [15:0] w);
		logic [NUMW-1:0] dv;
		dv_t             r;
		int unsigned     b;
		b  = QB - 1 - j;
		dv = NUMW'(w) << b;
		r  = a;
		if (a.num >= dv) begin
			r.num    = a.num - dv;
			r.quo[b] = 1'b1;
		end
		return r;
	endfunction

	// Square root stages
	sq_t        sq_in   [RW];
	sq_t        sq_s    [RW];
	ssvm_side_t sq_side_s [RW];
	logic [RW-1:0] sq_vld_s;

	always_comb begin
		sq_in[0].rem  = in_d2s;
		sq_in[0].root = '0;
		for (int k = 1; k < RW; k++) begin
			sq_in[k] = sq_s[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= '0;
		end else if (en) begin
			sq_vld_s <= {sq_vld_s[RW-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < RW; k++) begin
				sq_s[k] <= sq_step(sq_in[k], k);
			end
			sq_side_s[0] <= in_side;
			for (int k = 1; k < RW; k++) begin
				sq_side_s[k] <= sq_side_s[k-1];
			end
		end
	end

	// Band offset: clamp the root above the pass radius, flag a phase past the table
	logic [DSW-1:0] root_q;
	logic [DSW-1:0] diff_full;
	logic [15:0]    diff16;
	logic           zero_c;

	assign root_q    = sq_s[RW-1].root;
	assign diff_full = (root_q > DSW'(mask_radius)) ? (root_q - DSW'(mask_radius)) : '0;
	assign zero_c    = (diff_full >= DSW'(edge_width));
	assign diff16    = diff_full[15:0];

	// Divide stages, index 0 holds the offset scaled by the table depth
	dv_t           dv_in     [QB];
	dv_t           dv_s      [QB+1];
	logic          dv_zero_s [QB+1];
	ssvm_side_t    dv_side_s [QB+1];
	logic [QB:0]   dv_vld_s;

	always_comb begin
		for (int j = 0; j < QB; j++) begin
			dv_in[j] = dv_s[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s <= '0;
		end else if (en) begin
			dv_vld_s <= {dv_vld_s[QB-1:0], sq_vld_s[RW-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].num  <= NUMW'(diff16) * NUMW'(COS_TABLE_DEPTH);
			dv_s[0].quo  <= '0;
			dv_zero_s[0] <= zero_c;
			dv_side_s[0] <= sq_side_s[RW-1];
			for (int j = 0; j < QB; j++) begin
				dv_s[j+1]      <= dv_step(dv_in[j], j, edge_width);
				dv_zero_s[j+1] <= dv_zero_s[j];
				dv_side_s[j+1] <= dv_side_s[j];
			end
		end
	end

	assign out_valid = dv_vld_s[QB];
	assign out_idx   = dv_s[QB].quo;
	assign out_zero  = dv_zero_s[QB];
	assign out_side  = dv_side_s[QB];

endmodule

@@ design/soft_spherical_volume_mask_unit.sv @@
// Top level of the raised-cosine soft spherical volume mask.
// Voxels of a cubic volume stream in raster order (slowest axis first) on the s_ side, one
// word per voxel, and leave on the m_ side scaled by a radial weight: 1.0 inside
// mask_radius, a quarter-wave cosine across the band of edge_width, zero beyond. Both
// radii are unsigned Q8.8 voxels; the centre sits at grid_edge/2 on every axis. The
// weight is Q1.15 and the product is rounded half up and saturated to 16 bits. m_tlast
// marks the final voxel of the volume, after which the position counters wrap; a
// grid_edge below 2 or above MAX_GRID is clamped. With m_tready high the block takes one
// voxel per clock and delivers one per clock. Most of the pipeline depth comes from the
// square root, which spends one stage per result bit, and the band divider, which spends
// one stage per table index bit. A two-entry output (register plus skid) keeps s_tready
// registered: on a stalled m_ side the first result waits in the output register with
// input still open, the second parks in the skid entry and drops s_tready, which stays
// low until the skid word has moved into the output register.
// Write the configuration only while no voxels are in flight; no clearing pass is needed.
module soft_spherical_volume_mask_unit #(
	parameter int unsigned MAX_GRID        = ssvm_pkg::MAX_GRID_DEF,
	parameter int unsigned COS_TABLE_DEPTH = ssvm_pkg::COS_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes
	input  logic                            cfg_we,
	input  logic [ssvm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssvm_pkg::CFG_DATA_W-1:0] cfg_data,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,   // [15:0] voxel_value
	// output words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,   // [15:0] masked_value
	output logic                            m_tlast    // volume_last
);
	import ssvm_pkg::*;

	localparam int unsigned CW   = $clog2(MAX_GRID);
	localparam int unsigned EW   = $clog2(MAX_GRID + 1);
	localparam int unsigned DW   = 2 * CW + 2;
	localparam int unsigned DSW  = DW + 16;
	localparam int unsigned CMPW = (DSW > 34) ? DSW : 34;
	localparam int unsigned QB   = $clog2(COS_TABLE_DEPTH);

	// ------------------------------------------------------------------
	// Configuration registers and derived squared thresholds
	// ------------------------------------------------------------------
	logic [8:0]  grid_edge_q;
	logic [15:0] mask_radius_q;
	logic [15:0] edge_width_q;
	logic [31:0] rr_q;   // R^2
	logic [33:0] bb_q;   // (R+W)^2
	logic [16:0] band_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_edge_q   <= GRID_EDGE_RST;
			mask_radius_q <= MASK_RADIUS_RST;
			edge_width_q  <= EDGE_WIDTH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_EDGE:   grid_edge_q   <= cfg_data[8:0];
				REG_MASK_RADIUS: mask_radius_q <= cfg_data;
				REG_EDGE_WIDTH:  edge_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Thresholds are registered from the configuration registers, well before a voxel reaches stage 3
	assign band_c = 17'(mask_radius_q) + 17'(edge_width_q);

	always_ff @(posedge clk) begin
		rr_q <= 32'(mask_radius_q) * 32'(mask_radius_q);
		bb_q <= 34'(band_c) * 34'(band_c);
	end

	// ------------------------------------------------------------------
	// Pipeline enable: advance everything while the skid entry is free
	// ------------------------------------------------------------------
	logic en;
	logic skid_full_q;
	logic accept;

	assign en       = !skid_full_q;
	assign s_tready = en;
	assign accept   = s_tvalid && en;

	// ------------------------------------------------------------------
	// Position counters, effective edge and centre
	// ------------------------------------------------------------------
	logic [EW-1:0] edge_eff;
	logic [CW-1:0] top_c;
	logic [CW-1:0] ctr_c;
	logic [CW-1:0] slow_index_q;
	logic [CW-1:0] mid_index_q;
	logic [CW-1:0] fast_index_q;
	logic          last_f;
	logic          last_m;
	logic          last_s;

	always_comb begin
		if (32'(grid_edge_q) < 32'd2) begin
			edge_eff = EW'(2);
		end else if (32'(grid_edge_q) > 32'(MAX_GRID)) begin
			edge_eff = EW'(MAX_GRID);
		end else begin
			edge_eff = EW'(grid_edge_q);
		end
	end

	assign top_c  = CW'(edge_eff - EW'(1));
	assign ctr_c  = CW'(edge_eff >> 1);
	assign last_f = (fast_index_q >= top_c);
	assign last_m = (mid_index_q >= top_c);
	assign last_s = (slow_index_q >= top_c);

	// Fast axis counts every voxel, the others carry; everything wraps after the last voxel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_index_q <= '0;
			mid_index_q  <= '0;
			fast_index_q <= '0;
		end else if (accept) begin
			if (!last_f) begin
				fast_index_q <= fast_index_q + CW'(1);
			end else begin
				fast_index_q <= '0;
				if (!last_m) begin
					mid_index_q <= mid_index_q + CW'(1);
				end else begin
					mid_index_q <= '0;
					slow_index_q <= last_s ? '0 : (slow_index_q + CW'(1));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: axis offsets from the centre
	// ------------------------------------------------------------------
	logic               vld_s1;
	logic signed [15:0] voxel_s1;
	logic               last_s1;
	logic [CW-1:0]      off_slow_s1;
	logic [CW-1:0]      off_mid_s1;
	logic [CW-1:0]      off_fast_s1;

	function automatic logic [CW-1:0] abs_off(input logic [CW-1:0] p, input logic [CW-1:0] c);
		return (p >= c) ? (p - c) : (c - p);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			voxel_s1    <= $signed(s_tdata);
			last_s1     <= last_f && last_m && last_s;
			off_slow_s1 <= abs_off(slow_index_q, ctr_c);
			off_mid_s1  <= abs_off(mid_index_q, ctr_c);
			off_fast_s1 <= abs_off(fast_index_q, ctr_c);
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: squared distance
	// ------------------------------------------------------------------
	logic               vld_s2;
	logic signed [15:0] voxel_s2;
	logic               last_s2;
	logic [DW-1:0]      d2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			voxel_s2 <= voxel_s1;
			last_s2  <= last_s1;
			d2_s2    <= DW'(off_slow_s1) * DW'(off_slow_s1)
			          + DW'(off_mid_s1) * DW'(off_mid_s1)
			          + DW'(off_fast_s1) * DW'(off_fast_s1);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: pass and band tests on the Q8.8-scaled squared distance
	// ------------------------------------------------------------------
	logic [DSW-1:0] d2s_c;
	logic           vld_s3;
	logic [DSW-1:0] d2s_s3;
	ssvm_side_t     side_s3;

	assign d2s_c = {d2_s2, 16'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2s_s3         <= d2s_c;
			side_s3.voxel  <= voxel_s2;
			side_s3.last   <= last_s2;
			side_s3.pass   <= (CMPW'(d2s_c) <= CMPW'(rr_q));
			side_s3.inband <= (edge_width_q != 16'd0) && (CMPW'(d2s_c) <= CMPW'(bb_q));
		end
	end

	// ------------------------------------------------------------------
	// Root and divide pipeline: band phase index into the cosine table
	// ------------------------------------------------------------------
	logic          rd_valid;
	logic [QB-1:0] rd_idx;
	logic          rd_zero;
	ssvm_side_t    rd_side;

	ssvm_root_div #(
		.MAX_GRID        (MAX_GRID),
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH),
		.DSW             (DSW),
		.QB              (QB)
	) u_root_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (vld_s3),
		.in_d2s      (d2s_s3),
		.in_side     (side_s3),
		.mask_radius (mask_radius_q),
		.edge_width  (edge_width_q),
		.out_valid   (rd_valid),
		.out_idx     (rd_idx),
		.out_zero    (rd_zero),
		.out_side    (rd_side)
	);

	// ------------------------------------------------------------------
	// Stage 4: weight select from the quarter-wave table
	// ------------------------------------------------------------------
	logic [15:0] cos_rom [COS_TABLE_DEPTH];

	for (genvar gi = 0; gi < COS_TABLE_DEPTH; gi++) begin : g_cos
		assign cos_rom[gi] = cos_entry(gi, COS_TABLE_DEPTH);
	end

	logic               vld_s4;
	logic signed [15:0] voxel_s4;
	logic               last_s4;
	logic [15:0]        weight_s4;
	logic [15:0]        weight_c;

	always_comb begin
		if (rd_side.pass) begin
			weight_c = WEIGHT_ONE;
		end else if (rd_side.inband && !rd_zero && (32'(rd_idx) < COS_TABLE_DEPTH)) begin
			weight_c = cos_rom[rd_idx];
		end else begin
			weight_c = 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= rd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			voxel_s4  <= rd_side.voxel;
			last_s4   <= rd_side.last;
			weight_s4 <= weight_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: sample times weight
	// ------------------------------------------------------------------
	logic               vld_s5;
	logic               last_s5;
	logic signed [32:0] prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s5 <= last_s4;
			prod_s5 <= voxel_s4 * $signed({1'b0, weight_s4});
		end
	end

	// Round half up, drop the Q15 fraction, saturate
	logic signed [33:0] rnd_sum;
	logic signed [18:0] rnd_c;
	logic [15:0]        res_c;

	assign rnd_sum = 34'(prod_s5) + 34'sd16384;
	assign rnd_c   = 19'(rnd_sum >>> 15);

	always_comb begin
		if (rnd_c > 19'sd32767) begin
			res_c = 16'h7FFF;
		end else if (rnd_c < -19'sd32768) begin
			res_c = 16'h8000;
		end else begin
			res_c = rnd_c[15:0];
		end
	end

	// ------------------------------------------------------------------
	// Output register and skid entry
	// ------------------------------------------------------------------
	logic        out_vld_q;
	logic [15:0] out_data_q;
	logic        out_last_q;
	logic [15:0] skid_data_q;
	logic        skid_last_q;
	logic        out_load;

	assign out_load = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (out_load) begin
			if (skid_full_q) begin
				// drain the skid entry; the pipe holds this cycle
				out_vld_q   <= 1'b1;
				skid_full_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s5;
			end
		end else if (vld_s5 && en) begin
			// output is stalled: park the word leaving stage 5
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_full_q) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
			end else begin
				out_data_q <= res_c;
				out_last_q <= last_s5;
			end
		end else if (vld_s5 && en) begin
			skid_data_q <= res_c;
			skid_last_q <= last_s5;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

@@ tb/soft_spherical_volume_mask_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the soft spherical volume mask unit.
module soft_spherical_volume_mask_unit_tb;

	localparam int unsigned GRID_MAX      = ssvm_pkg::MAX_GRID_DEF;
	localparam int unsigned COS_DEPTH     = ssvm_pkg::COS_DEPTH_DEF;
	localparam int unsigned STUCK_LIMIT   = 3000;
	localparam int unsigned DIRECTED_VOX  = 25;
	localparam int unsigned RANDOM_VOX    = 1350;
	// drain time after the final results, with margin over the pipeline latency
	localparam int unsigned FLUSH_CYCLES  = 48;
	localparam int unsigned CORNER_COUNT  = 11;

	// Sample extremes and bit patterns used by the directed part
	localparam logic [15:0] CORNER_SAMPLES [CORNER_COUNT] = '{
		16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
		16'hAAAA, 16'h7FFE, 16'h8001, 16'h4000, 16'hC000
	};

	// One expected output word: masked sample plus end-of-volume flag
	typedef struct {
		logic [15:0] value;
		logic        last;
	} masked_word_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [ssvm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ssvm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;      // [15:0] voxel_value
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;             // [15:0] masked_value
	logic        m_tlast;             // volume_last

	// Predictor state: its own copy of the registers, position and weight table
	logic [15:0]  cos_q15 [COS_DEPTH];
	logic [8:0]   edge_cfg;
	logic [15:0]  radius_cfg;
	logic [15:0]  band_cfg;
	int unsigned  at_slow, at_mid, at_fast;
	masked_word_t expected_q [$];

	int unsigned  mismatches    = 0;
	int unsigned  voxels_sent   = 0;
	int unsigned  results_seen  = 0;
	int unsigned  volumes_seen  = 0;
	int unsigned  config_writes = 0;
	int unsigned  corner_k      = 0;
	int unsigned  stuck_cycles  = 0;
	int unsigned  ready_hold    = 0;
	bit           steady        = 1'b0;   // both sides run at full rate while set

	soft_spherical_volume_mask_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Weight arithmetic
	// ------------------------------------------------------------------

	// Quarter-wave cosine in Q1.15: nine-term Taylor series evaluated in Q30
	function automatic logic [15:0] cos_weight_at(input int unsigned i);
		longint unsigned phase, angle, angle_sq, term;
		longint          acc;
		longint          w;
		phase    = (64'(i) << 30) / COS_DEPTH;
		angle    = (phase * ssvm_pkg::HALF_PI_Q30) >> 30;
		angle_sq = (angle * angle) >> 30;
		term     = 64'd1 << 30;
		acc      = 64'sd1 << 30;
		for (int k = 1; k <= 8; k++) begin
			term = ((term * angle_sq) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		w = (acc > 0) ? (acc + 16384) / 32768 : 0;
		if (w > 32768) begin
			w = 32768;
		end
		return 16'(w);
	endfunction

	// Truncated square root, one result bit per trial
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned r, trial;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (64'd1 << b);
			if (trial * trial <= v) begin
				r = trial;
			end
		end
		return r;
	endfunction

	function automatic longint unsigned axis_sq(input int unsigned p, input int unsigned c);
		longint unsigned d;
		d = (p >= c) ? 64'(p - c) : 64'(c - p);
		return d * d;
	endfunction

	// Edge after clamping to 2..GRID_MAX
	function automatic int unsigned grid_n();
		if (edge_cfg < 2) begin
			return 2;
		end
		if (edge_cfg > GRID_MAX) begin
			return GRID_MAX;
		end
		return edge_cfg;
	endfunction

	// Raster advance; a counter at or past the top of its axis wraps
	function automatic void step_position(input int unsigned top,
			inout int unsigned s, inout int unsigned m, inout int unsigned f);
		if (f < top) begin
			f++;
		end else begin
			f = 0;
			if (m < top) begin
				m++;
			end else begin
				m = 0;
				s = (s < top) ? s + 1 : 0;
			end
		end
	endfunction

	// Voxels still to go before the predictor wraps to the origin, the last one included
	function automatic int unsigned voxels_left();
		int unsigned s, m, f, top, cnt;
		s   = at_slow;
		m   = at_mid;
		f   = at_fast;
		top = grid_n() - 1;
		cnt = 1;
		while (!(s >= top && m >= top && f >= top)) begin
			step_position(top, s, m, f);
			cnt++;
		end
		return cnt;
	endfunction

	// Weight the accepted sample by its radial position, queue the expected word, advance
	task automatic predict_voxel(input logic [15:0] raw);
		int unsigned        n, c, top;
		longint unsigned    dist_q16, band, r_q, diff, idx;
		longint             weight, prod;
		logic signed [15:0] sample;
		masked_word_t       word;
		n        = grid_n();
		c        = n / 2;
		top      = n - 1;
		sample   = raw;
		dist_q16 = (axis_sq(at_slow, c) + axis_sq(at_mid, c) + axis_sq(at_fast, c)) << 16;
		band     = 64'(radius_cfg) + 64'(band_cfg);
		weight   = 0;
		if (dist_q16 <= 64'(radius_cfg) * 64'(radius_cfg)) begin
			weight = 32768;
		end else if (band_cfg != 0 && dist_q16 <= band * band) begin
			r_q  = floor_root(dist_q16);
			diff = (r_q > radius_cfg) ? r_q - radius_cfg : 0;
			idx  = (diff * COS_DEPTH) / band_cfg;
			if (idx < COS_DEPTH) begin
				weight = cos_q15[idx];
			end
		end
		// round half up, then saturate
		prod = (longint'(sample) * weight + 16384) >>> 15;
		if (prod > 32767) begin
			prod = 32767;
		end else if (prod < -32768) begin
			prod = -32768;
		end
		word.value = 16'(prod);
		word.last  = (at_slow >= top) && (at_mid >= top) && (at_fast >= top);
		expected_q.push_back(word);
		step_position(top, at_slow, at_mid, at_fast);
	endtask

	initial begin : build_weights
		for (int i = 0; i < COS_DEPTH; i++) begin
			cos_q15[i] = cos_weight_at(i);
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: mirror register writes, predict on input words, check output words.
	// Everything is sampled at the rising edge, before the edge's own updates land.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : scoreboard
		masked_word_t want;
		if (!arst_n) begin
			edge_cfg   = ssvm_pkg::GRID_EDGE_RST;
			radius_cfg = ssvm_pkg::MASK_RADIUS_RST;
			band_cfg   = ssvm_pkg::EDGE_WIDTH_RST;
			at_slow    = 0;
			at_mid     = 0;
			at_fast    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ssvm_pkg::REG_GRID_EDGE:   edge_cfg   = cfg_data[8:0];
					ssvm_pkg::REG_MASK_RADIUS: radius_cfg = cfg_data;
					ssvm_pkg::REG_EDGE_WIDTH:  band_cfg   = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_voxel(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					if (mismatches < 10) begin
						$display("[%0t] unexpected word: value %h last %b, nothing pending",
							$realtime, m_tdata, m_tlast);
					end
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (m_tdata !== want.value || m_tlast !== want.last) begin
						if (mismatches < 10) begin
							$display("[%0t] word %0d: expected value %h last %b, got value %h last %b",
								$realtime, results_seen, want.value, want.last, m_tdata, m_tlast);
						end
						mismatches++;
					end
					if (want.last) begin
						volumes_seen++;
					end
				end
			end
		end
	end

	// Downstream pacing: mostly short ready/stall runs, now and then a long stall
	always @(posedge clk) begin : sink_pace
		int unsigned roll;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_hold <= 0;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				m_tready   <= 1'b1;
				ready_hold <= $urandom_range(0, 7);
			end else if (roll < 93) begin
				m_tready   <= 1'b0;
				ready_hold <= $urandom_range(0, 2);
			end else begin
				m_tready   <= 1'b0;
				ready_hold <= $urandom_range(15, 60);
			end
		end
	end

	// Watchdog: end the run if no word moves on either side for too long
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stuck_cycles <= 0;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("[%0t] watchdog: no word moved for %0d cycles", $realtime, stuck_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic int unsigned sender_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] random_voxel();
		if ($urandom_range(0, 9) == 0) begin
			return CORNER_SAMPLES[$urandom_range(0, 4)];
		end
		return 16'($urandom);
	endfunction

	function automatic logic [15:0] next_corner();
		logic [15:0] v;
		v = CORNER_SAMPLES[corner_k % CORNER_COUNT];
		corner_k++;
		return v;
	endfunction

	// Offer one voxel word, optionally after an idle gap, and hold it until taken
	task automatic send_voxel(input logic [15:0] v);
		int unsigned gap;
		gap = steady ? 0 : sender_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		voxels_sent++;
	endtask

	task automatic stream_random(input int unsigned count);
		repeat (count) send_voxel(random_voxel());
	endtask

	// Drop valid and hold off until every expected word has come back
	task automatic wait_all_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write; only called with nothing in flight
	task automatic write_reg(input ssvm_pkg::ssvm_reg_t idx,
			input logic [ssvm_pkg::CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		config_writes++;
	endtask

	task automatic write_mask(input logic [15:0] grid, input logic [15:0] radius,
			input logic [15:0] width);
		write_reg(ssvm_pkg::REG_GRID_EDGE, grid);
		write_reg(ssvm_pkg::REG_MASK_RADIUS, radius);
		write_reg(ssvm_pkg::REG_EDGE_WIDTH, width);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Sample extremes under the reset settings, a tiny grid with pass, band and zero
	// regions, zero band width, out-of-range edges and the widest radius and band
	task automatic test_directed();
		// reset settings: the corner voxels lie far outside the default sphere
		repeat (2) send_voxel(next_corner());
		wait_all_results();
		// 2-voxel grid, centre at 1: distances 0, 1, sqrt2 pass, sqrt3 falls in the band;
		// the edge shrink also wraps the counters left over from the 128 grid
		write_mask(16'd2, 16'h0180, 16'h0100);
		repeat (8) send_voxel(next_corner());
		wait_all_results();
		// edge 0 acts as 2; zero radius and zero band: only the centre voxel survives
		write_mask(16'd0, 16'h0000, 16'h0000);
		repeat (8) send_voxel(next_corner());
		wait_all_results();
		// edge 1 with stray upper data bits; widest radius and band pass everything
		write_mask(16'hFE01, 16'hFFFF, 16'hFFFF);
		repeat (7) send_voxel(next_corner());
		wait_all_results();
	endtask

	// Edges above the maximum clamp to it; shrink the edge mid-volume afterwards
	task automatic test_clamped_grid();
		// at edge 256 the first rows pass r = 181..221 voxels: straddle a 176 + 10 band
		write_mask(16'h01FF, 16'hB000, 16'h0A00);
		steady = 1'b1;
		stream_random(300);
		steady = 1'b0;
		wait_all_results();
		write_reg(ssvm_pkg::REG_GRID_EDGE, 16'd257);
		stream_random(20);
		wait_all_results();
		write_reg(ssvm_pkg::REG_GRID_EDGE, 16'd256);
		stream_random(20);
		wait_all_results();
		// fast counter sits far past the new top: it wraps at once
		write_reg(ssvm_pkg::REG_GRID_EDGE, 16'd4);
		stream_random(voxels_left());
		wait_all_results();
	endtask

	// Park all three counters beyond the top of a smaller grid; the next voxel ends the volume
	task automatic test_counters_beyond_edge();
		write_mask(16'd6, 16'h0200, 16'h0180);
		stream_random(6 * 6 * 4 + 6 * 4 + 4);
		wait_all_results();
		write_mask(16'd3, 16'h0100, 16'h0100);
		stream_random(voxels_left());
		stream_random(27);
		wait_all_results();
	endtask

	// Mostly whole volumes under random settings, with partial volumes and pauses mixed in
	task automatic test_random_volumes();
		int unsigned n, roll, radius, width, count;
		while (voxels_sent < DIRECTED_VOX + RANDOM_VOX) begin
			wait_all_results();
			n    = ($urandom_range(0, 99) < 75) ? $urandom_range(2, 5) : $urandom_range(6, 9);
			roll = $urandom_range(0, 9);
			radius = (roll == 0) ? 0 : (roll == 1) ? 16'hFFFF : $urandom_range(0, n * 256);
			roll = $urandom_range(0, 9);
			width = (roll == 0) ? 1 : (roll == 1) ? 16'hFFFF : (roll == 2) ? 0 :
				$urandom_range(1, n * 128);
			write_mask(16'(n), 16'(radius), 16'(width));
			steady = ($urandom_range(0, 3) == 0);
			count  = voxels_left();
			if ($urandom_range(0, 4) == 0) begin
				// broken volume: stop short, the next settings land mid-volume
				count = $urandom_range(1, count);
			end
			// keep the last volume inside the overall voxel budget
			if (count > DIRECTED_VOX + RANDOM_VOX - voxels_sent) begin
				count = DIRECTED_VOX + RANDOM_VOX - voxels_sent;
			end
			if ($urandom_range(0, 3) == 0) begin
				stream_random(count / 2);
				wait_all_results();
				count = count - count / 2;
			end
			stream_random(count);
			steady = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_clamped_grid();
		test_counters_beyond_edge();
		test_random_volumes();
		wait_all_results();
		repeat (FLUSH_CYCLES) @(posedge clk);
		$display("Streamed %0d voxels, checked %0d words across %0d completed volumes.",
			voxels_sent, results_seen, volumes_seen);
		$display("Covered %0d register writes: edges 0..511 with clamping, mid-volume shrinks,",
			config_writes);
		$display("zero and full radius, zero, unit and widest band, random stalls both sides.");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d words never arrived", mismatches, expected_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/ssvm_pkg.sv
design/ssvm_root_div.sv
design/soft_spherical_volume_mask_unit.sv
tb/soft_spherical_volume_mask_unit_tb.sv
